// ===== rtl/core/ppsf_pkg.sv =====
// shared types, constants and codes of the packet port steering filter
`timescale 1ns / 1ps

package ppsf_pkg;

	// field widths
	localparam int ByteW  = 8;
	localparam int QueueW = 8;
	localparam int TgtW   = 6;
	localparam int PortW  = 16;
	localparam int PosW   = 7;
	localparam int L4OffW = 7;
	localparam int CfgW   = 64;
	localparam int CfgIdxW = 2;

	// queue space and default queue count
	localparam int MaxQueues        = 64;
	localparam int QueueCountDefault = 64;

	// decoupling queue
	localparam int FifoDepth = 2;

	// header layout
	localparam logic [PosW-1:0] PosMax        = 7'd127;
	localparam logic [PosW-1:0] PosEthTypeHi  = 7'd12;
	localparam logic [PosW-1:0] PosEthTypeLo  = 7'd13;
	localparam logic [PosW-1:0] PosVerIhl     = 7'd14;
	localparam logic [PosW-1:0] PosFirstIp    = 7'd15;
	localparam logic [PosW-1:0] PosProtocol   = 7'd23;
	localparam logic [7:0]      EthHdrLen     = 8'd14;
	localparam logic [7:0]      IpHdrEnd      = 8'd34;
	localparam logic [7:0]      UdpHdrLen     = 8'd8;
	localparam logic [7:0]      TcpHdrLen     = 8'd20;
	localparam logic [3:0]      IhlMin        = 4'd5;
	localparam logic [ByteW-1:0] EthTypeHi    = 8'h08;
	localparam logic [ByteW-1:0] EthTypeLo    = 8'h00;
	localparam logic [ByteW-1:0] ProtoUdp     = 8'd17;
	localparam logic [ByteW-1:0] ProtoTcp     = 8'd6;
	localparam logic [PortW-1:0] UdpSteerPort = 16'd8080;
	localparam logic [PortW-1:0] TcpPortReset = 16'd443;

	// verdict codes
	typedef enum logic [1:0] {
		VERDICT_PASS     = 2'd0,
		VERDICT_DROP     = 2'd1,
		VERDICT_REDIRECT = 2'd2
	} ppsf_verdict_t;

	// policy modes, codes above pass all act as redirect all
	typedef enum logic [2:0] {
		MODE_REDIRECT_ALL = 3'd0,
		MODE_DROP_ALL     = 3'd1,
		MODE_UDP_STEER    = 3'd2,
		MODE_TCP_MATCH    = 3'd3,
		MODE_PASS_ALL     = 3'd4
	} ppsf_mode_t;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_POLICY_MODE      = 2'd0,
		REG_TCP_MATCH_PORT   = 2'd1,
		REG_BOUND_QUEUE_MASK = 2'd2
	} ppsf_reg_t;

	// classified frame handed from the parser to the policy stage
	typedef struct packed {
		logic              udp_hit;
		logic              tcp_ok;
		logic [PortW-1:0]  dest_port;
		logic [QueueW-1:0] queue;
	} ppsf_rec_t;

	// queue status
	typedef struct packed {
		logic full;
		logic empty;
	} ppsf_fifo_stat_t;

endpackage

// ===== rtl/core/ppsf_stream_if.sv =====
// valid/ready stream interfaces for frame bytes and verdicts
`timescale 1ns / 1ps

interface ppsf_in_if;
	import ppsf_pkg::*;
	logic              valid;
	logic              ready;
	logic [ByteW-1:0]  frame_byte;
	logic              frame_last;
	logic [QueueW-1:0] rx_queue;

	modport source (output valid, output frame_byte, output frame_last, output rx_queue,
		input ready);
	modport sink (input valid, input frame_byte, input frame_last, input rx_queue,
		output ready);
endinterface

interface ppsf_out_if;
	import ppsf_pkg::*;
	logic            valid;
	logic            ready;
	logic [1:0]      verdict;
	logic [TgtW-1:0] target_queue;

	modport source (output valid, output verdict, output target_queue, input ready);
	modport sink (input valid, input verdict, input target_queue, output ready);
endinterface

// ===== rtl/core/packet_port_steering_filter_unit.sv =====
// top level of the packet port steering filter
`timescale 1ns / 1ps

// Takes an Ethernet frame one byte per transaction on frames and returns one
// verdict (pass, drop or redirect with a socket queue) per frame; the frame's
// record goes through the two-entry queue of classified frames between header
// parser and policy stage, then the verdict register. Bytes are taken every
// cycle while that queue has room; the policy stage drains one frame per cycle
// into the verdict register while it is free or read out, so sustained rate is
// one byte per clock. The policy is read from the configuration registers when
// a frame leaves the queue; write them only while no frame is in flight.

module packet_port_steering_filter_unit
	import ppsf_pkg::*;
#(
	parameter int QUEUE_COUNT = QueueCountDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data,
	ppsf_in_if.sink            frames,
	ppsf_out_if.source         verdicts
);

	ppsf_fifo_stat_t fifo_stat;
	ppsf_rec_t       parse_rec;
	ppsf_rec_t       head_rec;
	logic            take;
	logic            push;
	logic            pop;

	// byte acceptance
	assign frames.ready = !fifo_stat.full;
	assign take         = frames.valid && frames.ready;

	ppsf_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.frame_byte (frames.frame_byte),
		.frame_last (frames.frame_last),
		.rx_queue   (frames.rx_queue),
		.push       (push),
		.rec        (parse_rec)
	);

	ppsf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (parse_rec),
		.pop    (pop),
		.rd_rec (head_rec),
		.stat   (fifo_stat)
	);

	ppsf_policy #(
		.QUEUE_COUNT (QUEUE_COUNT)
	) u_policy (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rec       (head_rec),
		.stat      (fifo_stat),
		.pop       (pop),
		.verdicts  (verdicts)
	);

	// only a redirect carries a queue index
	a_queue_zero: assert property (@(posedge clk) disable iff (!arst_n)
		verdicts.valid && (verdicts.verdict != VERDICT_REDIRECT)
			|-> (verdicts.target_queue == '0))
		else $error("non-redirect verdict with nonzero target queue");

	// a new verdict comes from a queued frame
	a_verdict_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(verdicts.valid) |-> $past(!fifo_stat.empty))
		else $error("verdict appeared with no classified frame queued");

	// a frame end always lands in the queue
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		take && frames.frame_last |=> !fifo_stat.empty)
		else $error("classified frame lost at the queue");

endmodule

// ===== rtl/core/ppsf_parser.sv =====
// front end: walks the ethernet and ipv4 headers and classifies each frame
`timescale 1ns / 1ps

module ppsf_parser
	import ppsf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [ByteW-1:0]  frame_byte,
	input  logic              frame_last,
	input  logic [QueueW-1:0] rx_queue,
	output logic              push,
	output ppsf_rec_t         rec
);

	logic [PosW-1:0]   pos_q;
	logic              eth_ok_q;
	logic [L4OffW-1:0] l4_off_q;
	logic [ByteW-1:0]  proto_q;
	logic [PortW-1:0]  port_q;
	logic              hdr_bad_q;
	logic [QueueW-1:0] qlatch_q;

	logic [7:0] pos_inc;
	logic [7:0] l4_ext;
	logic       hdr_ok;

	// header walk, frame state clears after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			eth_ok_q  <= 1'b0;
			l4_off_q  <= '0;
			proto_q   <= '0;
			port_q    <= '0;
			hdr_bad_q <= 1'b0;
			qlatch_q  <= '0;
		end else if (take) begin
			if (frame_last) begin
				pos_q     <= '0;
				eth_ok_q  <= 1'b0;
				l4_off_q  <= '0;
				proto_q   <= '0;
				port_q    <= '0;
				hdr_bad_q <= 1'b0;
				qlatch_q  <= '0;
			end else begin
				if (pos_q != PosMax) pos_q <= pos_q + 1'b1;
				if (pos_q == '0) qlatch_q <= rx_queue;
				if (pos_q == PosEthTypeHi) eth_ok_q <= (frame_byte == EthTypeHi);
				if (pos_q == PosEthTypeLo) eth_ok_q <= eth_ok_q && (frame_byte == EthTypeLo);
				if (pos_q == PosVerIhl) begin
					hdr_bad_q <= frame_byte[3:0] < IhlMin;
					l4_off_q  <= L4OffW'(EthHdrLen + {2'b00, frame_byte[3:0], 2'b00});
				end
				if (pos_q == PosProtocol) proto_q <= frame_byte;
				if (pos_q >= PosFirstIp) begin
					if ({1'b0, pos_q} == l4_ext + 8'd2) port_q[15:8] <= frame_byte;
					if ({1'b0, pos_q} == l4_ext + 8'd3) port_q[7:0]  <= frame_byte;
				end
			end
		end
	end

	// classification at the last byte, every header field is already stored
	always_comb begin
		pos_inc = {1'b0, pos_q} + 8'd1;
		l4_ext  = {1'b0, l4_off_q};
		hdr_ok  = eth_ok_q && !hdr_bad_q && (pos_inc >= IpHdrEnd);
		rec.udp_hit   = hdr_ok && (proto_q == ProtoUdp) && (pos_inc >= l4_ext + UdpHdrLen)
			&& (port_q == UdpSteerPort);
		rec.tcp_ok    = hdr_ok && (proto_q == ProtoTcp) && (pos_inc >= l4_ext + TcpHdrLen);
		rec.dest_port = port_q;
		rec.queue     = (pos_q == '0) ? rx_queue : qlatch_q;
		push          = take && frame_last;
	end

endmodule

// ===== rtl/core/ppsf_fifo.sv =====
// short queue of classified frames between parser and policy stage
`timescale 1ns / 1ps

module ppsf_fifo
	import ppsf_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ppsf_rec_t       wr_rec,
	input  logic            pop,
	output ppsf_rec_t       rd_rec,
	output ppsf_fifo_stat_t stat
);

	localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
	localparam int CntW = $clog2(FifoDepth + 1);

	ppsf_rec_t       mem_q [FifoDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_rec;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	assign rd_rec     = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CntW'(FifoDepth));
	assign stat.empty = (count_q == '0);

endmodule

// ===== rtl/core/ppsf_policy.sv =====
// back end: configuration registers, policy decision and verdict register
`timescale 1ns / 1ps

module ppsf_policy
	import ppsf_pkg::*;
#(
	parameter int QUEUE_COUNT = QueueCountDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data,
	input  ppsf_rec_t          rec,
	input  ppsf_fifo_stat_t    stat,
	output logic               pop,
	ppsf_out_if.source         verdicts
);

	logic [2:0]             mode_q;
	logic [PortW-1:0]       tcp_port_q;
	logic [QUEUE_COUNT-1:0] mask_q;

	logic                   out_valid_q;
	ppsf_verdict_t          verdict_q;
	logic [TgtW-1:0]        target_q;

	logic [MaxQueues-1:0]   mask_ext;
	logic                   do_steer;
	logic [QueueW-1:0]      steer_q;
	logic                   bound;
	ppsf_verdict_t          verdict_d;
	logic [TgtW-1:0]        target_d;

	// configuration writes, unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_REDIRECT_ALL;
			tcp_port_q <= TcpPortReset;
			mask_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLICY_MODE:      mode_q     <= cfg_data[2:0];
				REG_TCP_MATCH_PORT:   tcp_port_q <= cfg_data[PortW-1:0];
				REG_BOUND_QUEUE_MASK: mask_q     <= cfg_data[QUEUE_COUNT-1:0];
				default: ;
			endcase
		end
	end

	// policy decision for the head of the queue
	always_comb begin
		do_steer = 1'b0;
		steer_q  = '0;
		unique case (mode_q)
			MODE_DROP_ALL:  ;
			MODE_PASS_ALL:  ;
			MODE_UDP_STEER: do_steer = rec.udp_hit;
			MODE_TCP_MATCH: do_steer = rec.tcp_ok && (rec.dest_port == tcp_port_q);
			default: begin
				do_steer = 1'b1;
				steer_q  = rec.queue;
			end
		endcase

		// queues past the configured count read as unbound
		mask_ext = MaxQueues'(mask_q);
		bound    = (steer_q[QueueW-1:TgtW] == '0) && mask_ext[steer_q[TgtW-1:0]];

		verdict_d = VERDICT_PASS;
		target_d  = '0;
		if (mode_q == MODE_DROP_ALL) begin
			verdict_d = VERDICT_DROP;
		end else if (do_steer && bound) begin
			verdict_d = VERDICT_REDIRECT;
			target_d  = steer_q[TgtW-1:0];
		end

		pop = !stat.empty && (!out_valid_q || verdicts.ready);
	end

	// verdict output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (verdicts.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q <= verdict_d;
			target_q  <= target_d;
		end
	end

	assign verdicts.valid        = out_valid_q;
	assign verdicts.verdict      = verdict_q;
	assign verdicts.target_queue = target_q;

endmodule
